FILE: sv/hss_pkg.sv
// package for the harmonic sum synthesiser: default sizes, register indexes, field widths
// and the constant function that builds the quarter-wave sine table
// no dependencies
package hss_pkg;

  localparam int HARMONICS_DEF       = 8;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  localparam int MAX_HARMONICS = 8;
  localparam int INC_W         = 32;
  localparam int AMP_W         = 16;
  localparam int SINE_W        = 16;
  localparam int INDEX_W       = 32;
  localparam int OUT_W         = 20;
  localparam int CFG_W         = 64;
  localparam int CFG_ADDR_W    = 3;
  localparam int COUNT_W       = 4;

  localparam int TERM_W  = 32;
  localparam int PAIR_W  = TERM_W + 1;
  localparam int SUM_W   = TERM_W + 3;
  localparam int ROUND_SHIFT = 13;
  localparam int SHIFT_W = SUM_W - ROUND_SHIFT;

  localparam logic [CFG_ADDR_W-1:0] REG_COUNT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INC_A    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INC_B    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INC_C    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INC_D    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_LOW  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_HIGH = 3'd6;

  localparam logic [63:0] PI_Q30  = 64'hC90FDAA2;
  localparam logic [63:0] ONE_Q30 = 64'h40000000;

  // taylor series up to x^15 in q2.30, clamped, scaled to q1.15 with round half up
  function automatic logic [SINE_W-1:0] sine_entry(input int k, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] d;
    logic [63:0] s;
    longint      acc;
    logic [63:0] r;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    x    = (PI_Q30 * 64'(2 * k + 1)) >> (bits + 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      unique case (n)
        1:       d = 64'd6;
        2:       d = 64'd20;
        3:       d = 64'd42;
        4:       d = 64'd72;
        5:       d = 64'd110;
        6:       d = 64'd156;
        default: d = 64'd210;
      endcase
      // restoring long division, truncating
      num = (term * x2) >> 30;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem    = rem - d;
          quo[b] = 1'b1;
        end
      end
      term = quo;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    s = 64'(acc);
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    r = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return r[SINE_W-1:0];
  endfunction

endpackage

FILE: sv/harmonic_sum_synthesizer.sv
// top level of the harmonic sum synthesiser: seven-stage pipeline, one sine lane per harmonic
// depends on hss_pkg
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    sample_index_i
//   out      out_valid_o / out_stall_i  sample_value_o, saturated_o
//   cfg      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one item per cycle when the output is not stalled; value_q is loaded from sum_q
// stages: index, phase multiply, sine table read, amplitude multiply, two adder levels, round
// each stage holds its item while the next is full and stalled; empty stages fill up
// reset clears valid bits and configuration; the sine table is constant
module harmonic_sum_synthesizer #(
  parameter int HARMONICS       = hss_pkg::HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = hss_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = hss_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hss_pkg::INDEX_W-1:0]       sample_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hss_pkg::OUT_W-1:0]  sample_value_o,
  output logic                              saturated_o,
  input  logic                              cfg_we_i,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]    cfg_index_i,
  input  logic [hss_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int TOP_W      = SINE_TABLE_BITS + 2;
  localparam int STAGES     = 7;
  localparam int MAXH       = hss_pkg::MAX_HARMONICS;

  // configuration
  logic [hss_pkg::COUNT_W-1:0] count_q;
  logic [hss_pkg::CFG_W-1:0]   inc_q [4];
  logic [hss_pkg::CFG_W-1:0]   amp_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < 4; i++) inc_q[i] <= '0;
      for (int i = 0; i < 2; i++) amp_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hss_pkg::REG_COUNT:    count_q  <= cfg_data_i[hss_pkg::COUNT_W-1:0];
        hss_pkg::REG_INC_A:    inc_q[0] <= cfg_data_i;
        hss_pkg::REG_INC_B:    inc_q[1] <= cfg_data_i;
        hss_pkg::REG_INC_C:    inc_q[2] <= cfg_data_i;
        hss_pkg::REG_INC_D:    inc_q[3] <= cfg_data_i;
        hss_pkg::REG_AMP_LOW:  amp_q[0] <= cfg_data_i;
        hss_pkg::REG_AMP_HIGH: amp_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] v_d;
  logic [STAGES-1:0] ready;

  always_comb begin
    ready[STAGES-1] = ~v_q[STAGES-1] | ~out_stall_i;
    for (int s = STAGES - 2; s >= 0; s--) begin
      ready[s] = ~v_q[s] | ready[s+1];
    end
    v_d[0] = in_valid_i;
    for (int s = 1; s < STAGES; s++) begin
      v_d[s] = v_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (ready[s]) v_q[s] <= v_d[s];
      end
    end
  end

  assign in_stall_o  = ~ready[0];
  assign out_valid_o = v_q[STAGES-1];

  // constant quarter-wave table
  logic [hss_pkg::SINE_W-1:0] sine_lut [TABLE_SIZE];

  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_lut
    localparam logic [hss_pkg::SINE_W-1:0] Entry = hss_pkg::sine_entry(k, SINE_TABLE_BITS);
    assign sine_lut[k] = Entry;
  end

  // stage 0: index
  logic [hss_pkg::INDEX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (ready[0]) idx_q <= sample_index_i;
  end

  // lanes: phase, table read, amplitude product
  logic signed [hss_pkg::TERM_W-1:0] term_d [MAXH];
  logic signed [hss_pkg::TERM_W-1:0] term_q [MAXH];

  for (genvar h = 0; h < MAXH; h++) begin : g_lane
    if (h < HARMONICS) begin : g_on
      logic [hss_pkg::INC_W-1:0]  inc;
      logic [PHASE_BITS-1:0]      prod;
      logic [TOP_W-1:0]           top_q;
      logic [SINE_TABLE_BITS-1:0] addr;
      logic [hss_pkg::SINE_W-1:0] mag_q;
      logic                       neg_q;
      logic signed [hss_pkg::SINE_W:0]   sine;
      logic signed [hss_pkg::AMP_W-1:0]  amp;
      logic                              active;

      assign inc  = inc_q[h/2][(h%2)*hss_pkg::INC_W +: hss_pkg::INC_W];
      assign prod = idx_q[PHASE_BITS-1:0] * inc[PHASE_BITS-1:0];
      assign addr = top_q[TOP_W-2] ? ~top_q[SINE_TABLE_BITS-1:0]
                                   : top_q[SINE_TABLE_BITS-1:0];
      assign amp  = amp_q[h/4][(h%4)*hss_pkg::AMP_W +: hss_pkg::AMP_W];
      assign sine = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
      assign active = 32'(h) < 32'(count_q);
      assign term_d[h] = active ? hss_pkg::TERM_W'(sine) * hss_pkg::TERM_W'(amp) : '0;

      always_ff @(posedge clk_i) begin
        if (ready[1]) top_q <= prod[PHASE_BITS-1 -: TOP_W];
        if (ready[2]) begin
          mag_q <= sine_lut[addr];
          neg_q <= top_q[TOP_W-1];
        end
      end
    end else begin : g_off
      assign term_d[h] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      for (int h = 0; h < MAXH; h++) term_q[h] <= term_d[h];
    end
  end

  // adder tree
  logic signed [hss_pkg::PAIR_W-1:0] pair_q [4];
  logic signed [hss_pkg::SUM_W-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      for (int p = 0; p < 4; p++) begin
        pair_q[p] <= hss_pkg::PAIR_W'(term_q[2*p]) + hss_pkg::PAIR_W'(term_q[2*p+1]);
      end
    end
    if (ready[5]) begin
      sum_q <= hss_pkg::SUM_W'(pair_q[0]) + hss_pkg::SUM_W'(pair_q[1])
             + hss_pkg::SUM_W'(pair_q[2]) + hss_pkg::SUM_W'(pair_q[3]);
    end
  end

  // round half up to q6.14 and saturate
  logic signed [hss_pkg::SUM_W-1:0]   biased;
  logic signed [hss_pkg::SHIFT_W-1:0] shifted;
  logic                               over;
  logic                               under;
  logic signed [hss_pkg::OUT_W-1:0]   value_d;
  logic signed [hss_pkg::OUT_W-1:0]   value_q;
  logic                               sat_q;

  localparam logic signed [hss_pkg::SHIFT_W-1:0] OutMax = (1 <<< (hss_pkg::OUT_W - 1)) - 1;
  localparam logic signed [hss_pkg::SHIFT_W-1:0] OutMin = -(1 <<< (hss_pkg::OUT_W - 1));

  assign biased  = sum_q + hss_pkg::SUM_W'(1 << (hss_pkg::ROUND_SHIFT - 1));
  assign shifted = hss_pkg::SHIFT_W'(biased >>> hss_pkg::ROUND_SHIFT);
  assign over    = shifted > OutMax;
  assign under   = shifted < OutMin;

  always_comb begin
    priority if (over) begin
      value_d = OutMax[hss_pkg::OUT_W-1:0];
    end else if (under) begin
      value_d = OutMin[hss_pkg::OUT_W-1:0];
    end else begin
      value_d = shifted[hss_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      value_q <= value_d;
      sat_q   <= over | under;
    end
  end

  assign sample_value_o = value_q;
  assign saturated_o    = sat_q;

endmodule

FILE: test/hss_sample_checker.sv
`timescale 1ns / 100ps
// checker for the harmonic sum synthesiser: snoops the register port and both item channels,
// predicts each sample from its own register copy and sine table, and compares in order
// depends on hss_pkg
module hss_sample_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [hss_pkg::INDEX_W-1:0]       sample_index_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [hss_pkg::OUT_W-1:0]  sample_value_i,
  input  logic                              saturated_i,
  input  logic                              cfg_we_i,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]    cfg_index_i,
  input  logic [hss_pkg::CFG_W-1:0]         cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  localparam int          TABLE_BITS  = hss_pkg::SINE_TABLE_BITS_DEF;
  localparam int          TABLE_LEN   = 1 << TABLE_BITS;
  localparam int          PHASE_W     = hss_pkg::PHASE_BITS_DEF;
  localparam int          FRAC_DROP   = 13;
  localparam int          REPORT_MAX  = 10;
  localparam logic [63:0] PI_Q2_30    = 64'hC90F_DAA2;
  localparam logic [63:0] UNITY_Q2_30 = 64'h4000_0000;
  localparam longint      SAMPLE_MAX  = 524287;
  localparam longint      SAMPLE_MIN  = -524288;

  typedef struct packed {
    logic signed [hss_pkg::OUT_W-1:0] value;
    logic                             clipped;
  } sample_t;

  logic [hss_pkg::SINE_W-1:0]  quarter_sine [TABLE_LEN];
  logic [hss_pkg::COUNT_W-1:0] count_q;
  logic [hss_pkg::CFG_W-1:0]   inc_pairs [4];
  logic [hss_pkg::CFG_W-1:0]   amp_quads [2];
  sample_t                     expected_samples [$];
  sample_t                     want;

  // taylor series of sin up to x^15 in q2.30, clamped to [0, 1], scaled to q1.15
  function automatic logic [hss_pkg::SINE_W-1:0] quarter_sine_at(input int unsigned k);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] power;
    logic [63:0] scaled;
    longint      series;
    angle    = (PI_Q2_30 * 64'(2 * k + 1)) >> (TABLE_BITS + 2);
    angle_sq = (angle * angle) >> 30;
    power    = angle;
    series   = longint'(angle);
    for (int n = 1; n <= 7; n++) begin
      power = ((power * angle_sq) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        series = series - longint'(power);
      end else begin
        series = series + longint'(power);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    if (series > longint'(UNITY_Q2_30)) begin
      series = longint'(UNITY_Q2_30);
    end
    scaled = (64'(series) * 64'd32767 + (UNITY_Q2_30 >> 1)) >> 30;
    return scaled[hss_pkg::SINE_W-1:0];
  endfunction

  function automatic sample_t predict_sample(input logic [hss_pkg::INDEX_W-1:0] index);
    int unsigned                      active;
    longint                           acc;
    longint                           rounded;
    logic [hss_pkg::INC_W-1:0]        inc;
    logic signed [hss_pkg::AMP_W-1:0] amp;
    logic [PHASE_W-1:0]               phase;
    logic [1:0]                       quadrant;
    logic [TABLE_BITS-1:0]            slot;
    int                               sine;
    sample_t                          result;
    active = (count_q > hss_pkg::HARMONICS_DEF) ? hss_pkg::HARMONICS_DEF : count_q;
    acc    = 0;
    for (int h = 0; h < active; h++) begin
      inc      = inc_pairs[h / 2][hss_pkg::INC_W * (h % 2) +: hss_pkg::INC_W];
      amp      = amp_quads[h / 4][hss_pkg::AMP_W * (h % 4) +: hss_pkg::AMP_W];
      phase    = PHASE_W'(index * inc);
      quadrant = phase[PHASE_W-1 -: 2];
      slot     = phase[PHASE_W-3 -: TABLE_BITS];
      if (quadrant[0]) begin
        slot = ~slot;
      end
      sine = int'(quarter_sine[slot]);
      if (quadrant[1]) begin
        sine = -sine;
      end
      acc = acc + longint'(sine) * longint'(amp);
    end
    rounded        = (acc + 4096) >>> FRAC_DROP;
    result.clipped = 1'b1;
    if (rounded > SAMPLE_MAX) begin
      rounded = SAMPLE_MAX;
    end else if (rounded < SAMPLE_MIN) begin
      rounded = SAMPLE_MIN;
    end else begin
      result.clipped = 1'b0;
    end
    result.value = rounded[hss_pkg::OUT_W-1:0];
    return result;
  endfunction

  initial begin
    for (int k = 0; k < TABLE_LEN; k++) begin
      quarter_sine[k] = quarter_sine_at(k);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      inc_pairs[0] <= '0;
      inc_pairs[1] <= '0;
      inc_pairs[2] <= '0;
      inc_pairs[3] <= '0;
      amp_quads[0] <= '0;
      amp_quads[1] <= '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_samples.push_back(predict_sample(sample_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          if (fail_count_o < REPORT_MAX) begin
            $display("%0t: sample %0d clipped %0b arrived with nothing expected",
                     $time, sample_value_i, saturated_i);
          end
          fail_count_o++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_value_i !== want.value || saturated_i !== want.clipped) begin
            if (fail_count_o < REPORT_MAX) begin
              $display("%0t: sample mismatch, expected %0d clipped %0b, got %0d clipped %0b",
                       $time, $signed(want.value), want.clipped, sample_value_i, saturated_i);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          hss_pkg::REG_COUNT:    count_q      <= cfg_data_i[hss_pkg::COUNT_W-1:0];
          hss_pkg::REG_INC_A:    inc_pairs[0] <= cfg_data_i;
          hss_pkg::REG_INC_B:    inc_pairs[1] <= cfg_data_i;
          hss_pkg::REG_INC_C:    inc_pairs[2] <= cfg_data_i;
          hss_pkg::REG_INC_D:    inc_pairs[3] <= cfg_data_i;
          hss_pkg::REG_AMP_LOW:  amp_quads[0] <= cfg_data_i;
          hss_pkg::REG_AMP_HIGH: amp_quads[1] <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

FILE: test/tb_harmonic_sum_synthesizer.sv
`timescale 1ns / 100ps
// testbench top for the harmonic sum synthesiser: clock, reset, register settings and
// index stimulus with random idling on both channels; the verdict comes from hss_sample_checker
// depends on hss_pkg, harmonic_sum_synthesizer and hss_sample_checker
module tb_harmonic_sum_synthesizer;

  localparam int                             IDLE_PCT        = 29;
  localparam int                             HOLD_CYCLES     = 64;
  localparam int                             QUIET_LIMIT     = 1000;
  localparam int                             DRAIN_CYCLES    = 16;
  localparam int                             RANDOM_PHASES   = 12;
  localparam int                             ITEMS_PER_PHASE = 160;
  localparam logic [hss_pkg::CFG_ADDR_W-1:0] REG_SPARE       = 3'd7;

  typedef enum int {AMP_QUIET, AMP_ANY, AMP_EXTREME} amp_style_e;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             in_valid     = 1'b0;
  logic [hss_pkg::INDEX_W-1:0]      sample_index = '0;
  logic                             out_stall    = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [hss_pkg::CFG_ADDR_W-1:0]   cfg_index    = hss_pkg::REG_COUNT;
  logic [hss_pkg::CFG_W-1:0]        cfg_data     = '0;
  wire                              in_stall;
  wire                              out_valid;
  wire signed [hss_pkg::OUT_W-1:0]  sample_value;
  wire                              saturated;
  int unsigned                      fail_count;
  int unsigned                      pending;

  bit                               idle_on      = 1'b1;
  int unsigned                      hold_req     = 0;
  int unsigned                      quiet_cycles = 0;
  logic [hss_pkg::CFG_W-1:0]        count_word;
  logic [hss_pkg::CFG_W-1:0]        inc_words [4];
  logic [hss_pkg::CFG_W-1:0]        amp_words [2];

  always #1 clk = ~clk;

  harmonic_sum_synthesizer i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_index_i (sample_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_value_o (sample_value),
    .saturated_o    (saturated),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  hss_sample_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .sample_index_i (sample_index),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .sample_value_i (sample_value),
    .saturated_i    (saturated),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  task automatic send_index(input logic [hss_pkg::INDEX_W-1:0] index);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_index <= index;
    do @(posedge clk); while (in_stall);
  endtask

  // first wait covers the item accepted at the current edge
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [hss_pkg::CFG_ADDR_W-1:0] index,
                           input logic [hss_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_registers();
    write_reg(hss_pkg::REG_COUNT, count_word);
    write_reg(hss_pkg::REG_INC_A, inc_words[0]);
    write_reg(hss_pkg::REG_INC_B, inc_words[1]);
    write_reg(hss_pkg::REG_INC_C, inc_words[2]);
    write_reg(hss_pkg::REG_INC_D, inc_words[3]);
    write_reg(hss_pkg::REG_AMP_LOW, amp_words[0]);
    write_reg(hss_pkg::REG_AMP_HIGH, amp_words[1]);
    write_reg(REG_SPARE, {$urandom(), $urandom()});
    cfg_we <= 1'b0;
  endtask

  task automatic fill_setting(input logic [hss_pkg::CFG_W-1:0] count,
                              input logic [hss_pkg::INC_W-1:0] inc,
                              input logic [hss_pkg::AMP_W-1:0] amp);
    count_word = count;
    for (int p = 0; p < 4; p++) begin
      inc_words[p] = {2{inc}};
    end
    for (int q = 0; q < 2; q++) begin
      amp_words[q] = {4{amp}};
    end
  endtask

  task automatic pick_setting();
    logic [hss_pkg::INC_W-1:0] base;
    logic [hss_pkg::AMP_W-1:0] amp;
    amp_style_e                style;
    count_word = {$urandom(), $urandom()};
    if ($urandom_range(3) == 0) begin
      count_word[hss_pkg::COUNT_W-1:0] = hss_pkg::COUNT_W'($urandom());
    end else begin
      count_word[hss_pkg::COUNT_W-1:0] =
        hss_pkg::COUNT_W'($urandom_range(1, hss_pkg::HARMONICS_DEF));
    end
    base  = hss_pkg::INC_W'($urandom_range(1, 1 << 27));
    style = amp_style_e'($urandom_range(2));
    for (int h = 0; h < hss_pkg::HARMONICS_DEF; h++) begin
      if ($urandom_range(1) == 0) begin
        inc_words[h / 2][hss_pkg::INC_W * (h % 2) +: hss_pkg::INC_W] =
          hss_pkg::INC_W'(base * (h + 1));
      end else begin
        inc_words[h / 2][hss_pkg::INC_W * (h % 2) +: hss_pkg::INC_W] = $urandom();
      end
      case (style)
        AMP_QUIET: amp = hss_pkg::AMP_W'($urandom_range(8191)) - hss_pkg::AMP_W'(4096);
        AMP_ANY:   amp = hss_pkg::AMP_W'($urandom());
        default: begin
          case ($urandom_range(3))
            0:       amp = 16'h7FFF;
            1:       amp = 16'h8000;
            2:       amp = 16'hFFFF;
            default: amp = 16'h0001;
          endcase
        end
      endcase
      amp_words[h / 4][hss_pkg::AMP_W * (h % 4) +: hss_pkg::AMP_W] = amp;
    end
  endtask

  initial begin : receiver
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_req) begin
        served = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [hss_pkg::INDEX_W-1:0] run_index;
    logic [hss_pkg::INDEX_W-1:0] index;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // silence with registers at reset
    send_index(32'h0000_0000);
    send_index(32'hFFFF_FFFF);
    drain();

    // full positive amplitudes, quarter-turn steps: peaks clip both ways
    fill_setting(64'd8, 32'h4000_0000, 16'h7FFF);
    program_registers();
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'd2);
    send_index(32'd3);
    drain();

    // count above the harmonic limit, most negative amplitudes
    fill_setting(64'hFFFF_FFFF_FFFF_FFF9, 32'hFFFF_FFFF, 16'h8000);
    program_registers();
    send_index(32'h8000_0000);
    send_index(32'h7FFF_FFFF);
    send_index(32'hFFFF_FFFF);
    send_index(32'hAAAA_AAAA);
    send_index(32'h5555_5555);
    drain();

    // every register all ones
    fill_setting('1, 32'hFFFF_FFFF, 16'hFFFF);
    program_registers();
    send_index(32'd1);
    send_index(32'h1234_5678);
    send_index(32'hFFFF_FFFE);
    drain();

    // one harmonic at unit amplitude, one table entry per index across quadrant edges
    fill_setting(64'd1, 32'h0010_0000, 16'h1000);
    amp_words[0][hss_pkg::CFG_W-1:hss_pkg::AMP_W] =
      (hss_pkg::CFG_W - hss_pkg::AMP_W)'({$urandom(), $urandom()});
    program_registers();
    send_index(32'd1023);
    send_index(32'd1024);
    send_index(32'd2047);
    send_index(32'd3072);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_setting();
      program_registers();
      idle_on = (p != 3);
      if (p == 5 || p == 9) begin
        hold_req++;
      end
      run_index = $urandom();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(3))
          0, 1: begin
            index     = run_index;
            run_index = run_index + 1;
          end
          2:       index = $urandom();
          default: index = hss_pkg::INDEX_W'($urandom_range(1023));
        endcase
        send_index(index);
      end
      drain();
    end

    idle_on = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
